// ===== design/tpdp_pkg.sv =====
// Shared package for the ternary packed dot-product engine.
// Holds field widths, register codes, reset values and the queue entry type.
// No dependencies.
package tpdp_pkg;

  // Field and datapath widths
  localparam int LANES      = 4;
  localparam int ACT_W      = 8;
  localparam int WBYTE_W    = 8;
  localparam int CODE_W     = 2;
  localparam int SCALE_W    = 24;
  localparam int RL_W       = 13;
  localparam int IDX_W      = 16;
  localparam int SUM_W      = 21;
  localparam int SCALED_W   = 51;
  localparam int SCALED_LSB = 16;
  localparam int PROD_W     = 2 * SCALE_W;             // scale product width
  localparam int HALF_W     = SCALE_W;                 // split point of the product
  localparam int MHI_W      = SUM_W + HALF_W;          // sum times signed upper half
  localparam int MLO_W      = SUM_W + HALF_W + 1;      // sum times unsigned lower half
  localparam int FULL_W     = SUM_W + PROD_W;          // full sum * scale product
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Defaults for top-level parameters
  localparam int MAX_REDUCTION_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Register reset values
  localparam logic [SCALE_W-1:0] ACT_SCALE_RST = SCALE_W'(65536);
  localparam logic [SCALE_W-1:0] WT_SCALE_RST  = SCALE_W'(65536);
  localparam logic [RL_W-1:0]    RED_LEN_RST   = RL_W'(4096);
  localparam logic [IDX_W-1:0]   COL_COUNT_RST = IDX_W'(1);
  localparam logic [IDX_W-1:0]   ROW_COUNT_RST = IDX_W'(1);

  // Weight codes; the two remaining codes mean zero
  localparam logic [CODE_W-1:0] WCODE_NEG = 2'b00;
  localparam logic [CODE_W-1:0] WCODE_POS = 2'b10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACT_SCALE = 3'd0,
    CFG_WT_SCALE  = 3'd1,
    CFG_RED_LEN   = 3'd2,
    CFG_COL_COUNT = 3'd3,
    CFG_ROW_COUNT = 3'd4
  } cfg_reg_t;

  // Matrix shape settings seen by the front end
  typedef struct packed {
    logic [RL_W-1:0]  red_len;
    logic [IDX_W-1:0] col_count;
    logic [IDX_W-1:0] row_count;
  } shape_cfg_t;

  // One finished dot product waiting for scaling
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    done;
  } dot_entry_t;

  // Queue status flags
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== design/tpdp_queue.sv =====
// Small flop-based FIFO between the accumulate front end and the scaling back end.
// Depends on tpdp_pkg for the status struct.
module tpdp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   rd_en,
  output logic [WIDTH-1:0]       rd_data,
  output tpdp_pkg::queue_stat_t  stat
);
  import tpdp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rd_data    = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/tpdp_front.sv =====
// Front end: accepts input transactions, masks lanes, accumulates the ternary sum
// and tracks output position. Finished products go to the queue. Uses tpdp_pkg.
module tpdp_front #(
  parameter int MAX_REDUCTION = tpdp_pkg::MAX_REDUCTION_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  tpdp_pkg::shape_cfg_t                               shape,
  input  logic                                               in_valid,
  output logic                                               in_stall,
  input  logic [tpdp_pkg::WBYTE_W-1:0]                       weight_byte,
  input  logic [tpdp_pkg::LANES-1:0][tpdp_pkg::ACT_W-1:0]    acts,
  input  tpdp_pkg::queue_stat_t                              q_stat,
  output logic                                               push,
  output tpdp_pkg::dot_entry_t                               push_entry
);
  import tpdp_pkg::*;

  localparam int TP_W = $clog2(MAX_REDUCTION + 1);
  localparam int CW   = ((RL_W > TP_W) ? RL_W : TP_W) + 1;

  logic [TP_W-1:0]         term_pos;
  logic signed [SUM_W-1:0] run_sum;
  logic [IDX_W-1:0]        col_idx;
  logic [IDX_W-1:0]        row_idx;

  logic [CW-1:0]           klen;
  logic [CW-1:0]           tp_ext;
  logic signed [SUM_W-1:0] sum_next;
  logic                    complete;
  logic [IDX_W-1:0]        cols;
  logic [IDX_W-1:0]        rows;
  logic [IDX_W:0]          col_p1;
  logic [IDX_W:0]          row_p1;
  logic                    col_last;
  logic                    row_last;
  logic                    accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Effective reduction length, clamped to 1..MAX_REDUCTION
  always_comb begin
    if (shape.red_len == '0) begin
      klen = CW'(1);
    end else if (CW'(shape.red_len) > CW'(MAX_REDUCTION)) begin
      klen = CW'(MAX_REDUCTION);
    end else begin
      klen = CW'(shape.red_len);
    end
  end

  assign tp_ext   = CW'(term_pos);
  assign complete = (tp_ext + CW'(LANES)) >= klen;

  // Four-lane ternary add; lanes past the length drop out
  always_comb begin
    sum_next = run_sum;
    for (int i = 0; i < LANES; i++) begin
      if ((tp_ext + CW'(i)) < klen) begin
        case (weight_byte[CODE_W*i +: CODE_W])
          WCODE_NEG: sum_next = sum_next - SUM_W'($signed(acts[i]));
          WCODE_POS: sum_next = sum_next + SUM_W'($signed(acts[i]));
          default:   sum_next = sum_next;
        endcase
      end
    end
  end

  // Output position, zero counts act as one
  assign cols     = (shape.col_count == '0) ? IDX_W'(1) : shape.col_count;
  assign rows     = (shape.row_count == '0) ? IDX_W'(1) : shape.row_count;
  assign col_p1   = {1'b0, col_idx} + (IDX_W+1)'(1);
  assign row_p1   = {1'b0, row_idx} + (IDX_W+1)'(1);
  assign col_last = col_p1 >= {1'b0, cols};
  assign row_last = row_p1 >= {1'b0, rows};

  assign push            = accept && complete;
  assign push_entry.row  = row_idx;
  assign push_entry.col  = col_idx;
  assign push_entry.sum  = sum_next;
  assign push_entry.done = col_last && row_last;

  // Accumulator and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      term_pos <= '0;
      run_sum  <= '0;
      col_idx  <= '0;
      row_idx  <= '0;
    end else if (accept) begin
      if (complete) begin
        term_pos <= '0;
        run_sum  <= '0;
        if (col_last) begin
          col_idx <= '0;
          row_idx <= row_last ? '0 : row_p1[IDX_W-1:0];
        end else begin
          col_idx <= col_p1[IDX_W-1:0];
        end
      end else begin
        term_pos <= term_pos + TP_W'(LANES);
        run_sum  <= sum_next;
      end
    end
  end

endmodule

// ===== design/tpdp_back.sv =====
// Back end: pops finished sums, multiplies by the product of both scales in two
// partial products, recombines, and holds the result for the output channel.
// Uses tpdp_pkg.
module tpdp_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [tpdp_pkg::SCALE_W-1:0]   act_scale,
  input  logic signed [tpdp_pkg::SCALE_W-1:0]   wt_scale,
  input  tpdp_pkg::queue_stat_t                 q_stat,
  input  tpdp_pkg::dot_entry_t                  q_entry,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tpdp_pkg::IDX_W-1:0]            out_row,
  output logic [tpdp_pkg::IDX_W-1:0]            out_col,
  output logic signed [tpdp_pkg::SUM_W-1:0]     dot_sum,
  output logic signed [tpdp_pkg::SCALED_W-1:0]  scaled_value,
  output logic                                  matrix_done
);
  import tpdp_pkg::*;

  logic signed [PROD_W-1:0] p_next;
  logic signed [PROD_W-1:0] p_reg;
  logic signed [HALF_W-1:0] p_hi;
  logic [HALF_W-1:0]        p_lo;
  logic signed [MHI_W-1:0]  mhi_w;
  logic signed [MLO_W-1:0]  mlo_w;

  logic                     a_valid;
  dot_entry_t               a_entry;
  logic signed [MHI_W-1:0]  a_mhi;
  logic signed [MLO_W-1:0]  a_mlo;
  logic signed [FULL_W-1:0] full_prod;

  logic                     ready_out;
  logic                     ready_a;

  // Scale product, refreshed every cycle from the registers
  assign p_next = act_scale * wt_scale;
  always_ff @(posedge clk) begin
    p_reg <= p_next;
  end

  assign p_hi = p_reg[PROD_W-1:HALF_W];
  assign p_lo = p_reg[HALF_W-1:0];

  // Partial products of sum times scale product
  assign mhi_w = $signed(q_entry.sum) * p_hi;
  assign mlo_w = $signed(q_entry.sum) * $signed({1'b0, p_lo});

  // Recombine; the floor shift is a plain bit select
  assign full_prod = (FULL_W'(a_mhi) <<< HALF_W) + FULL_W'(a_mlo);

  // Per-stage flow control
  assign ready_out = !out_valid || !out_stall;
  assign ready_a   = !a_valid || ready_out;
  assign pop       = !q_stat.empty && ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid <= pop;
      end
      if (ready_out) begin
        out_valid <= a_valid;
      end
    end
  end

  // Multiply stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      a_entry <= q_entry;
      a_mhi   <= mhi_w;
      a_mlo   <= mlo_w;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (ready_out && a_valid) begin
      out_row      <= a_entry.row;
      out_col      <= a_entry.col;
      dot_sum      <= a_entry.sum;
      matrix_done  <= a_entry.done;
      scaled_value <= full_prod[SCALED_LSB+SCALED_W-1:SCALED_LSB];
    end
  end

endmodule

// ===== design/ternary_packed_dot_product.sv =====
// Top level of the ternary packed dot-product engine: configuration registers,
// front end, result queue and scaling back end. Uses tpdp_pkg, tpdp_front,
// tpdp_queue and tpdp_back.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_stall   | weight_byte, act_lane0..act_lane3
//  out     | out_valid / out_stall | out_row, out_col, dot_sum, scaled_value, matrix_done
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input transaction is taken per cycle while the result queue has room.
// A completed dot product is written to the queue on the edge that accepts the
// transaction finishing it, then enters the multiply stage register and then the
// output register; out_stall can hold it in the queue or in either register.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full, i.e. when the
// output side has been stalled long enough. cfg_ready is always high.
// Synchronous active-high reset restores register defaults and empties the pipe.
module ternary_packed_dot_product #(
  parameter int MAX_REDUCTION = tpdp_pkg::MAX_REDUCTION_DEF,
  parameter int QUEUE_DEPTH   = tpdp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tpdp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tpdp_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [tpdp_pkg::WBYTE_W-1:0]          weight_byte,
  input  logic signed [tpdp_pkg::ACT_W-1:0]     act_lane0,
  input  logic signed [tpdp_pkg::ACT_W-1:0]     act_lane1,
  input  logic signed [tpdp_pkg::ACT_W-1:0]     act_lane2,
  input  logic signed [tpdp_pkg::ACT_W-1:0]     act_lane3,
  // results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tpdp_pkg::IDX_W-1:0]            out_row,
  output logic [tpdp_pkg::IDX_W-1:0]            out_col,
  output logic signed [tpdp_pkg::SUM_W-1:0]     dot_sum,
  output logic signed [tpdp_pkg::SCALED_W-1:0]  scaled_value,
  output logic                                  matrix_done
);
  import tpdp_pkg::*;

  logic signed [SCALE_W-1:0]          act_scale;
  logic signed [SCALE_W-1:0]          wt_scale;
  shape_cfg_t                         shape;
  logic [LANES-1:0][ACT_W-1:0]        acts;
  logic                               push;
  dot_entry_t                         push_entry;
  logic                               pop;
  dot_entry_t                         q_entry;
  logic [$bits(dot_entry_t)-1:0]      q_rd_data;
  queue_stat_t                        q_stat;

  assign cfg_ready = 1'b1;
  assign acts      = {act_lane3, act_lane2, act_lane1, act_lane0};
  assign q_entry   = dot_entry_t'(q_rd_data);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      act_scale       <= ACT_SCALE_RST;
      wt_scale        <= WT_SCALE_RST;
      shape.red_len   <= RED_LEN_RST;
      shape.col_count <= COL_COUNT_RST;
      shape.row_count <= ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ACT_SCALE: act_scale       <= cfg_data[SCALE_W-1:0];
        CFG_WT_SCALE:  wt_scale        <= cfg_data[SCALE_W-1:0];
        CFG_RED_LEN:   shape.red_len   <= cfg_data[RL_W-1:0];
        CFG_COL_COUNT: shape.col_count <= cfg_data[IDX_W-1:0];
        CFG_ROW_COUNT: shape.row_count <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  tpdp_front #(
    .MAX_REDUCTION(MAX_REDUCTION)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .shape      (shape),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .weight_byte(weight_byte),
    .acts       (acts),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  tpdp_queue #(
    .WIDTH($bits(dot_entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(push_entry),
    .rd_en  (pop),
    .rd_data(q_rd_data),
    .stat   (q_stat)
  );

  tpdp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .act_scale   (act_scale),
    .wt_scale    (wt_scale),
    .q_stat      (q_stat),
    .q_entry     (q_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .dot_sum     (dot_sum),
    .scaled_value(scaled_value),
    .matrix_done (matrix_done)
  );

  // Queue never written while full
  assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("queue written while full");

  // Back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // Reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule
